### hdl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Types and constants shared by the H.264 RTP depacketizer blocks.
// ----------------------------------------------------------------------------
package hrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PtW     = 7;
  localparam int unsigned LenW    = 13;
  localparam int unsigned StatusW = 3;
  localparam int unsigned UnitW   = 16;

  localparam logic [PtW-1:0] PT_RESET = 7'd96;

  localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
  localparam logic [4:0] NAL_STAP_A     = 5'd24;
  localparam logic [4:0] NAL_FU_A       = 5'd28;
  localparam logic [4:0] NAL_UNHANDLED_MAX = 5'd29;

  typedef enum logic [StatusW-1:0] {
    ST_DATA       = 3'd0,
    ST_FRAME_END  = 3'd1,
    ST_BAD_PT     = 3'd2,
    ST_UNHANDLED  = 3'd3,
    ST_UNKNOWN    = 3'd4,
    ST_UNIT_LONG  = 3'd5,
    ST_FU_SHORT   = 3'd6
  } status_e;

  // results caused by one input transaction: optional start code,
  // optional final result, frame end flag on the last one
  typedef struct packed {
    logic             start;
    logic             tail;
    logic [ByteW-1:0] tail_byte;
    status_e          tail_status;
    logic             frame_end;
  } desc_t;

endpackage

### hdl/hrd_in_if.sv
// ----------------------------------------------------------------------------
// hrd_in_if
// Payload byte channel into the depacketizer.
// ----------------------------------------------------------------------------
interface hrd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_of_packet;
  logic [12:0] packet_length;
  logic [6:0]  rtp_payload_type;
  logic        last_of_frame;

  modport source (
    output valid, payload_byte, first_of_packet, packet_length,
           rtp_payload_type, last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, payload_byte, first_of_packet, packet_length,
           rtp_payload_type, last_of_frame,
    output ready
  );
endinterface

### hdl/hrd_out_if.sv
// ----------------------------------------------------------------------------
// hrd_out_if
// Annex-B stream channel out of the depacketizer.
// ----------------------------------------------------------------------------
interface hrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic [2:0] status;
  logic       frame_end;

  modport source (
    output valid, stream_byte, status, frame_end,
    input  ready
  );

  modport sink (
    input  valid, stream_byte, status, frame_end,
    output ready
  );
endinterface

### hdl/hrd_parser.sv
// ----------------------------------------------------------------------------
// hrd_parser
// Packet/NAL parsing state; turns each input transaction into a result
// descriptor for the emitter.
// ----------------------------------------------------------------------------
module hrd_parser #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [hrd_pkg::PtW-1:0]  cfg_wdata_i,
  hrd_in_if.sink                   in_if,
  input  logic                     take_ok_i,
  output logic                     push_o,
  output hrd_pkg::desc_t           desc_o
);
  import hrd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PACKET_BYTES);
  localparam int unsigned WideW = 17;
  localparam logic [WideW-1:0] MaxLen = WideW'(MAX_PACKET_BYTES);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_PASS,
    MODE_FUHDR,
    MODE_GAP,
    MODE_SIZELO,
    MODE_UNIT
  } mode_e;

  mode_e              mode_q, mode_d;
  logic [CntW-1:0]    left_q, left_d;
  logic [UnitW-1:0]   unit_q, unit_d;
  logic [ByteW-1:0]   hi_q, hi_d;
  logic [2:0]         ind_q, ind_d;
  logic               discard_q, discard_d;
  logic [PtW-1:0]     pt_q;

  logic               accept;
  logic [4:0]         hdr_type;
  logic [WideW-1:0]   len_min, len_sat;
  logic [UnitW-1:0]   size;
  logic [UnitW-1:0]   unit_dec;
  status_e            err;
  desc_t              desc;

  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = take_ok_i;
  assign hdr_type = in_if.payload_byte[4:0];
  assign size     = {hi_q, in_if.payload_byte};
  assign unit_dec = (unit_q != '0) ? unit_q - UnitW'(1) : unit_q;

  always_comb begin
    len_min = WideW'(in_if.packet_length);
    if (len_min == '0) begin
      len_min = WideW'(1);
    end
    len_sat = (len_min > MaxLen) ? MaxLen : len_min;
  end

  always_comb begin
    mode_d    = mode_q;
    left_d    = left_q;
    unit_d    = unit_q;
    hi_d      = hi_q;
    ind_d     = ind_q;
    discard_d = discard_q;
    desc      = '0;
    err       = ST_DATA;

    if (discard_q) begin
      if (in_if.last_of_frame) begin
        discard_d        = 1'b0;
        mode_d           = MODE_IDLE;
        left_d           = '0;
        desc.tail        = 1'b1;
        desc.tail_status = ST_FRAME_END;
        desc.frame_end   = 1'b1;
      end
    end else begin
      if (in_if.first_of_packet) begin
        left_d = CntW'(len_sat - WideW'(1));
        unit_d = '0;
        hi_d   = '0;
        mode_d = MODE_IDLE;
        if (in_if.rtp_payload_type != pt_q) begin
          err = ST_BAD_PT;
        end else if (hdr_type <= NAL_SINGLE_MAX) begin
          desc.start     = 1'b1;
          desc.tail      = 1'b1;
          desc.tail_byte = in_if.payload_byte;
          mode_d         = MODE_PASS;
        end else if (hdr_type == NAL_STAP_A) begin
          mode_d = MODE_GAP;
        end else if (hdr_type == NAL_FU_A) begin
          if (len_sat < WideW'(3)) begin
            err = ST_FU_SHORT;
          end else begin
            ind_d  = in_if.payload_byte[7:5];
            mode_d = MODE_FUHDR;
          end
        end else if (hdr_type <= NAL_UNHANDLED_MAX) begin
          err = ST_UNHANDLED;
        end else begin
          err = ST_UNKNOWN;
        end
      end else if (mode_q == MODE_IDLE || left_q == '0) begin
        mode_d = MODE_IDLE;
      end else begin
        left_d = left_q - CntW'(1);
        case (mode_q)
          MODE_PASS: begin
            desc.tail      = 1'b1;
            desc.tail_byte = in_if.payload_byte;
          end
          MODE_FUHDR: begin
            if (in_if.payload_byte[7]) begin
              desc.start     = 1'b1;
              desc.tail      = 1'b1;
              desc.tail_byte = {ind_q, in_if.payload_byte[4:0]};
            end
            mode_d = MODE_PASS;
          end
          MODE_GAP: begin
            // a remainder of two bytes or fewer cannot hold a size and unit data
            if (WideW'(left_q) > WideW'(2)) begin
              hi_d   = in_if.payload_byte;
              mode_d = MODE_SIZELO;
            end
          end
          MODE_SIZELO: begin
            if (WideW'(size) > WideW'(left_d)) begin
              err = ST_UNIT_LONG;
            end else begin
              desc.start = 1'b1;
              if (size == '0) begin
                mode_d = MODE_GAP;
              end else begin
                unit_d = size;
                mode_d = MODE_UNIT;
              end
            end
          end
          MODE_UNIT: begin
            desc.tail      = 1'b1;
            desc.tail_byte = in_if.payload_byte;
            unit_d         = unit_dec;
            if (unit_dec == '0) begin
              mode_d = MODE_GAP;
            end
          end
          default: begin
            mode_d = MODE_IDLE;
          end
        endcase
      end

      if (err != ST_DATA) begin
        desc.tail        = 1'b1;
        desc.tail_byte   = '0;
        desc.tail_status = err;
        mode_d           = MODE_IDLE;
        left_d           = '0;
        unit_d           = '0;
        if (!in_if.last_of_frame) begin
          discard_d = 1'b1;
        end
      end

      if (in_if.last_of_frame) begin
        if (!desc.start && !desc.tail) begin
          desc.tail        = 1'b1;
          desc.tail_status = ST_FRAME_END;
        end
        desc.frame_end = 1'b1;
        mode_d         = MODE_IDLE;
        left_d         = '0;
        unit_d         = '0;
      end
    end
  end

  assign push_o = accept && (desc.start || desc.tail);
  assign desc_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      left_q    <= '0;
      unit_q    <= '0;
      hi_q      <= '0;
      ind_q     <= '0;
      discard_q <= 1'b0;
      pt_q      <= PT_RESET;
    end else begin
      if (cfg_we_i) begin
        pt_q <= cfg_wdata_i;
      end
      if (accept) begin
        mode_q    <= mode_d;
        left_q    <= left_d;
        unit_q    <= unit_d;
        hi_q      <= hi_d;
        ind_q     <= ind_d;
        discard_q <= discard_d;
      end
    end
  end

endmodule

### hdl/hrd_emitter.sv
// ----------------------------------------------------------------------------
// hrd_emitter
// Result register; plays out a descriptor as start code bytes and a final
// result, one transaction per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module hrd_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrd_pkg::desc_t desc_i,
  output logic           take_ok_o,
  hrd_out_if.source      out_if
);
  import hrd_pkg::*;

  logic       busy_q;
  logic [2:0] idx_q;
  desc_t      desc_q;
  logic [2:0] total;
  logic       is_last;
  logic       in_start;
  logic       out_done;

  // start code is four results, the final result one more
  assign total    = {desc_q.start, 1'b0, desc_q.tail};
  assign is_last  = (idx_q == total - 3'd1);
  assign in_start = desc_q.start && (idx_q < 3'd4);
  assign out_done = out_if.valid && out_if.ready && is_last;

  assign take_ok_o = !busy_q || out_done;

  assign out_if.valid       = busy_q;
  assign out_if.stream_byte = in_start ? ((idx_q == 3'd3) ? 8'h01 : 8'h00)
                                       : desc_q.tail_byte;
  assign out_if.status      = in_start ? ST_DATA : desc_q.tail_status;
  assign out_if.frame_end   = is_last && desc_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      desc_q <= '0;
    end else begin
      if (push_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        desc_q <= desc_i;
      end else if (out_done) begin
        busy_q <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule

### hdl/h264_rtp_payload_depacketizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_payload_depacketizer
// Turns H.264 RTP payload bytes into an Annex-B byte stream. Single NAL,
// STAP-A and FU-A packets are handled; other NAL types, a wrong payload
// type, an oversized STAP-A unit or a short FU-A packet give one error
// result and the rest of the frame is dropped. A payload byte is taken
// whenever the result register is empty or hands out its last result in the
// same cycle, so bytes with one result or none flow at one per cycle while
// the receiver is ready. A byte that opens a NAL unit produces a four byte
// start code, then the header byte where that is passed on; the next byte
// waits for the last of them. The single result register sets throughput,
// one result per cycle while the receiver is ready (none to five per byte).
// ----------------------------------------------------------------------------
module h264_rtp_payload_depacketizer #(
  parameter int unsigned MAX_PACKET_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [hrd_pkg::PtW-1:0]  cfg_wdata_i,
  hrd_in_if.sink                   in_if,
  hrd_out_if.source                out_if
);
  import hrd_pkg::*;

  logic  push;
  logic  take_ok;
  desc_t desc;

  hrd_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .take_ok_i   (take_ok),
    .push_o      (push),
    .desc_o      (desc)
  );

  hrd_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .desc_i    (desc),
    .take_ok_o (take_ok),
    .out_if    (out_if)
  );

endmodule

### verif/h264_rtp_payload_depacketizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_payload_depacketizer_tb
// Self-checking bench for the H.264 RTP depacketizer. A short directed table
// covers the error codes, restarts, saturated lengths and empty STAP-A units.
// It is followed by random frames of single NAL, STAP-A and FU-A packets
// mixed with broken packets and stray bytes, run under several accepted
// payload types. Outputs are checked against a local model or typed rows.
// ----------------------------------------------------------------------------
module h264_rtp_payload_depacketizer_tb;
  import hrd_pkg::*;

  localparam int MAX_PKT     = 4096;
  localparam int DIR_N       = 27;
  localparam int PHASE_N     = 5;
  localparam int PHASE_ITEMS = 72;
  localparam int DRAIN_TAIL  = 8;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic [12:0] plen;
    logic [6:0]  ptype;
    logic        last;
    logic        typed;
    status_e     exp_status;
    logic        exp_fe;
  } pay_item_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    status_e    status;
    logic       frame_end;
  } annexb_res_t;

  typedef enum logic [2:0] {
    PM_IDLE, PM_PASS, PM_FU_HDR, PM_GAP, PM_SIZE_LO, PM_UNIT
  } pmode_e;

  typedef enum logic [1:0] {
    RX_STEADY, RX_COIN, RX_SPARSE, RX_EVERY4
  } rx_mode_e;

  // directed rows; typed rows carry their single expected result
  localparam pay_item_t DIR_TAB [DIR_N] = '{
    // single NAL with saturated length, then restarted by a new packet
    '{8'h65, 1'b1, 13'h1fff, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd0, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h41, 1'b1, 13'd2, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'hff, 1'b0, 13'd2, 7'd96, 1'b1, 1'b0, ST_DATA, 1'b0},
    // stray byte while idle closes a frame with no data
    '{8'h12, 1'b0, 13'd5, 7'd127, 1'b1, 1'b1, ST_FRAME_END, 1'b1},
    '{8'h65, 1'b1, 13'd4, 7'd0, 1'b0, 1'b1, ST_BAD_PT, 1'b0},
    '{8'haa, 1'b0, 13'd4, 7'd0, 1'b1, 1'b1, ST_FRAME_END, 1'b1},
    '{8'hff, 1'b1, 13'd1, 7'd96, 1'b1, 1'b1, ST_UNKNOWN, 1'b1},
    '{8'h19, 1'b1, 13'd6, 7'd96, 1'b0, 1'b1, ST_UNHANDLED, 1'b0},
    // new packet start is swallowed while the frame is discarded
    '{8'h3c, 1'b1, 13'd6, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd6, 7'd96, 1'b1, 1'b1, ST_FRAME_END, 1'b1},
    // zero length counts as one, so this FU-A is too short
    '{8'h1c, 1'b1, 13'd0, 7'd96, 1'b1, 1'b1, ST_FU_SHORT, 1'b1},
    '{8'hfc, 1'b1, 13'd4, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h85, 1'b0, 13'd4, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd4, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'hff, 1'b0, 13'd4, 7'd96, 1'b1, 1'b0, ST_DATA, 1'b0},
    // STAP-A: empty unit, two byte unit, then an oversized one
    '{8'h78, 1'b1, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h00, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h02, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h41, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'h42, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'hff, 1'b0, 13'd11, 7'd96, 1'b0, 1'b0, ST_DATA, 1'b0},
    '{8'hff, 1'b0, 13'd11, 7'd96, 1'b0, 1'b1, ST_UNIT_LONG, 1'b0},
    '{8'h55, 1'b0, 13'd11, 7'd96, 1'b1, 1'b1, ST_FRAME_END, 1'b1},
    '{8'h00, 1'b1, 13'd1, 7'd96, 1'b1, 1'b0, ST_DATA, 1'b0}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [PtW-1:0] cfg_wdata_i;

  hrd_in_if  in_if ();
  hrd_out_if out_if ();

  h264_rtp_payload_depacketizer #(
    .MAX_PACKET_BYTES(MAX_PKT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // model state
  logic [6:0]  accepted_pt = PT_RESET;
  pmode_e      pmode       = PM_IDLE;
  logic [12:0] pkt_left    = '0;
  logic [15:0] unit_left   = '0;
  logic [7:0]  size_hi     = '0;
  logic [2:0]  ind_top     = '0;
  logic        discarding  = 1'b0;

  annexb_res_t step_res [$];
  annexb_res_t annexb_q [$];
  pay_item_t   drv_item;
  pay_item_t   frame_items [$];
  logic [7:0]  pkt_bytes [$];

  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;
  int       burst_left   = 0;
  int       offered_cnt  = 0;
  bit       hold_req     = 1'b0;
  int       hold_len     = 0;
  int       hold_left    = 0;
  rx_mode_e rx_mode      = RX_STEADY;
  int       rx_phase     = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void emit(input logic [7:0] b, input status_e st);
    step_res.push_back(annexb_res_t'{b, st, 1'b0});
  endfunction

  function automatic void emit_start_code();
    emit(8'h00, ST_DATA);
    emit(8'h00, ST_DATA);
    emit(8'h00, ST_DATA);
    emit(8'h01, ST_DATA);
  endfunction

  // results of one accepted payload byte, left in step_res
  function automatic void depack_step(input pay_item_t it);
    logic [4:0]  nal;
    logic [12:0] eff_len;
    logic [12:0] prior;
    logic [15:0] unit_size;
    status_e     fault;
    step_res.delete();
    fault = ST_DATA;
    if (discarding) begin
      if (it.last) begin
        discarding = 1'b0;
        pmode      = PM_IDLE;
        pkt_left   = '0;
        emit(8'h00, ST_FRAME_END);
        step_res[0].frame_end = 1'b1;
      end
      return;
    end
    if (it.first) begin
      nal     = it.data[4:0];
      eff_len = (it.plen == 13'd0) ? 13'd1 : it.plen;
      if (eff_len > MAX_PKT) eff_len = 13'(MAX_PKT);
      pkt_left  = eff_len - 13'd1;
      unit_left = '0;
      size_hi   = '0;
      pmode     = PM_IDLE;
      if (it.ptype != accepted_pt) begin
        fault = ST_BAD_PT;
      end else if (nal <= NAL_SINGLE_MAX) begin
        emit_start_code();
        emit(it.data, ST_DATA);
        pmode = PM_PASS;
      end else if (nal == NAL_STAP_A) begin
        pmode = PM_GAP;
      end else if (nal == NAL_FU_A) begin
        if (eff_len < 13'd3) begin
          fault = ST_FU_SHORT;
        end else begin
          ind_top = it.data[7:5];
          pmode   = PM_FU_HDR;
        end
      end else if (nal <= NAL_UNHANDLED_MAX) begin
        fault = ST_UNHANDLED;
      end else begin
        fault = ST_UNKNOWN;
      end
    end else if (pmode == PM_IDLE || pkt_left == 13'd0) begin
      pmode = PM_IDLE;
    end else begin
      prior    = pkt_left;
      pkt_left = prior - 13'd1;
      case (pmode)
        PM_PASS: begin
          emit(it.data, ST_DATA);
        end
        PM_FU_HDR: begin
          // start bit set: rebuild the original NAL header
          if (it.data[7]) begin
            emit_start_code();
            emit({ind_top, it.data[4:0]}, ST_DATA);
          end
          pmode = PM_PASS;
        end
        PM_GAP: begin
          // two bytes or fewer left cannot hold a size and unit data, drop them
          if (prior > 13'd2) begin
            size_hi = it.data;
            pmode   = PM_SIZE_LO;
          end
        end
        PM_SIZE_LO: begin
          unit_size = {size_hi, it.data};
          if (unit_size > pkt_left) begin
            fault = ST_UNIT_LONG;
          end else begin
            emit_start_code();
            if (unit_size == 16'd0) begin
              pmode = PM_GAP;
            end else begin
              unit_left = unit_size;
              pmode     = PM_UNIT;
            end
          end
        end
        PM_UNIT: begin
          emit(it.data, ST_DATA);
          if (unit_left > 16'd0) unit_left = unit_left - 16'd1;
          if (unit_left == 16'd0) pmode = PM_GAP;
        end
        default: begin
          pmode = PM_IDLE;
        end
      endcase
    end
    if (fault != ST_DATA) begin
      emit(8'h00, fault);
      pmode     = PM_IDLE;
      pkt_left  = '0;
      unit_left = '0;
      if (!it.last) discarding = 1'b1;
    end
    if (it.last) begin
      if (step_res.size() == 0) emit(8'h00, ST_FRAME_END);
      step_res[step_res.size()-1].frame_end = 1'b1;
      pmode     = PM_IDLE;
      pkt_left  = '0;
      unit_left = '0;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  // prediction on input transactions, comparison on output transactions
  always @(posedge clk_i) begin : scoreboard
    annexb_res_t got;
    annexb_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) accepted_pt = cfg_wdata_i;
      if (in_if.valid && in_if.ready) begin
        depack_step(drv_item);
        if (drv_item.typed) begin
          annexb_q.push_back(annexb_res_t'{8'h00, drv_item.exp_status, drv_item.exp_fe});
        end else begin
          foreach (step_res[i]) annexb_q.push_back(step_res[i]);
        end
      end
      if (out_if.valid && out_if.ready) begin
        got = annexb_res_t'{out_if.stream_byte, status_e'(out_if.status), out_if.frame_end};
        if (annexb_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte %02h status %0d end %0b",
                                  got.stream_byte, got.status, got.frame_end));
        end else begin
          want = annexb_q.pop_front();
          if (got !== want) begin
            flag_mismatch($sformatf("got byte %02h status %0d end %0b, want %02h %0d %0b",
                                    got.stream_byte, got.status, got.frame_end,
                                    want.stream_byte, want.status, want.frame_end));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
               annexb_q.size());
      $display("h264_rtp_payload_depacketizer: mismatch");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus long hold-offs on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = hold_len;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_phase++;
        case (rx_mode)
          RX_STEADY: out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 9) != 0);
          default:   out_if.ready <= (rx_phase[1:0] != 2'd3);
        endcase
      end
    end
  end

  // offers one payload byte and returns at the edge that accepts it
  task automatic send_byte(input pay_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid            <= 1'b1;
    in_if.payload_byte     <= it.data;
    in_if.first_of_packet  <= it.first;
    in_if.packet_length    <= it.plen;
    in_if.rtp_payload_type <= it.ptype;
    in_if.last_of_frame    <= it.last;
    drv_item               <= it;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (annexb_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  task automatic write_pt(input logic [6:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic void add_bytes(input int n);
    repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // turns the collected packet bytes into payload transactions
  function automatic void flush_packet(input logic [6:0] pt, input logic [12:0] len,
                                       input bit lead);
    foreach (pkt_bytes[i]) begin
      frame_items.push_back(pay_item_t'{
        pkt_bytes[i], lead && (i == 0),
        (i == 0) ? len : 13'($urandom_range(0, 8191)),
        (i == 0) ? pt : 7'($urandom_range(0, 127)),
        1'b0, 1'b0, ST_DATA, 1'b0});
    end
    if (lead) offered_cnt += pkt_bytes.size();
    pkt_bytes.delete();
  endfunction

  task automatic build_frame(input logic [6:0] gen_pt);
    int         kind;
    int         parts;
    int         units;
    int         unit_len;
    logic [4:0] nal;
    frame_items.delete();
    repeat ($urandom_range(1, 3)) begin
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        pkt_bytes.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 23))});
        add_bytes($urandom_range(0, 7));
        flush_packet(gen_pt, 13'(pkt_bytes.size()), 1'b1);
      end else if (kind < 45) begin
        pkt_bytes.push_back({3'($urandom_range(0, 7)), NAL_STAP_A});
        units = $urandom_range(1, 3);
        repeat (units) begin
          unit_len = $urandom_range(0, 4);
          pkt_bytes.push_back(8'h00);
          pkt_bytes.push_back(8'(unit_len));
          add_bytes(unit_len);
        end
        add_bytes($urandom_range(0, 2));
        flush_packet(gen_pt, 13'(pkt_bytes.size()), 1'b1);
      end else if (kind < 70) begin
        // FU-A fragments: start bit on the first, end bit on the last
        nal   = 5'($urandom_range(0, 31));
        parts = $urandom_range(1, 3);
        for (int p = 0; p < parts; p++) begin
          pkt_bytes.push_back({3'($urandom_range(0, 7)), NAL_FU_A});
          pkt_bytes.push_back({p == 0, p == parts - 1, 1'($urandom_range(0, 1)), nal});
          add_bytes($urandom_range(1, 5));
          flush_packet(gen_pt, 13'(pkt_bytes.size()), 1'b1);
        end
      end else if (kind < 75) begin
        pkt_bytes.push_back(8'($urandom_range(0, 255)));
        add_bytes($urandom_range(0, 3));
        flush_packet(gen_pt ^ 7'($urandom_range(1, 127)), 13'(pkt_bytes.size()), 1'b1);
      end else if (kind < 80) begin
        nal = 5'($urandom_range(25, 31));
        if (nal == NAL_FU_A) nal = NAL_UNHANDLED_MAX;
        pkt_bytes.push_back({3'($urandom_range(0, 7)), nal});
        add_bytes($urandom_range(0, 3));
        flush_packet(gen_pt, 13'(pkt_bytes.size()), 1'b1);
      end else if (kind < 85) begin
        // STAP-A whose unit size runs past the packet
        pkt_bytes.push_back({3'($urandom_range(0, 7)), NAL_STAP_A});
        pkt_bytes.push_back(8'($urandom_range(1, 255)));
        add_bytes($urandom_range(1, 4));
        flush_packet(gen_pt, 13'(pkt_bytes.size()), 1'b1);
      end else if (kind < 90) begin
        pkt_bytes.push_back({3'($urandom_range(0, 7)), NAL_FU_A});
        add_bytes($urandom_range(0, 2));
        flush_packet(gen_pt, 13'($urandom_range(0, 2)), 1'b1);
      end else if (kind < 95) begin
        add_bytes($urandom_range(1, 3));
        flush_packet(gen_pt, 13'($urandom_range(0, 8191)), 1'b0);
      end else begin
        // declared length unrelated to the bytes that follow
        pkt_bytes.push_back({3'($urandom_range(0, 7)), 5'($urandom_range(0, 23))});
        add_bytes($urandom_range(0, 6));
        flush_packet(gen_pt, 13'($urandom_range(0, 8191)), 1'b1);
      end
    end
    // sometimes the frame ends inside a packet
    if (frame_items.size() > 2 && $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 2)) void'(frame_items.pop_back());
    end
    frame_items[frame_items.size()-1].last = 1'b1;
  endtask

  initial begin
    logic [6:0] phase_pt;
    int         phase_start;
    in_if.valid            <= 1'b0;
    in_if.payload_byte     <= '0;
    in_if.first_of_packet  <= 1'b0;
    in_if.packet_length    <= '0;
    in_if.rtp_payload_type <= '0;
    in_if.last_of_frame    <= 1'b0;
    drv_item               <= '0;
    cfg_we_i               <= 1'b0;
    cfg_wdata_i            <= '0;
    rst_ni                 <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) send_byte(DIR_TAB[r]);
    in_if.valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < PHASE_N; p++) begin
      case (p)
        0:       phase_pt = 7'd0;
        1:       phase_pt = 7'd127;
        3:       phase_pt = PT_RESET;
        default: phase_pt = 7'($urandom_range(0, 127));
      endcase
      write_pt(phase_pt);
      // long receiver hold-off while bytes keep coming
      if (p % 2 == 1) begin
        hold_len = $urandom_range(80, 120);
        hold_req = 1'b1;
      end
      phase_start = offered_cnt;
      while (offered_cnt - phase_start < PHASE_ITEMS) begin
        build_frame(phase_pt);
        foreach (frame_items[i]) send_byte(frame_items[i]);
      end
      in_if.valid <= 1'b0;
      wait_drained();
    end

    if (annexb_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", annexb_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("h264_rtp_payload_depacketizer: match");
    end else begin
      $display("h264_rtp_payload_depacketizer: mismatch");
    end
    $finish;
  end

endmodule

### files.f
hdl/hrd_pkg.sv
hdl/hrd_in_if.sv
hdl/hrd_out_if.sv
hdl/hrd_parser.sv
hdl/hrd_emitter.sv
hdl/h264_rtp_payload_depacketizer.sv
verif/h264_rtp_payload_depacketizer_tb.sv
